// ===== rtl/hnhp_pkg.sv =====
// Shared types and constants of the notification header parser.
`default_nettype none

package hnhp_pkg;

	// Frame layout.
	localparam int MAX_ADDRESS_BYTES = 4;
	localparam int DATE_TIME_BYTES   = 12;
	localparam int CHECK_BYTES       = 2;
	localparam int LINK_BYTES        = 3;
	localparam int INVOKE_BYTES      = 4;
	localparam logic [31:0] LENGTH_MASK = 32'h0000_07FF;

	// Queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_FMT1   = 4'd1,
		PH_FMT2   = 4'd2,
		PH_DEST   = 4'd3,
		PH_SRC    = 4'd4,
		PH_CTRL   = 4'd5,
		PH_CHECK  = 4'd6,
		PH_LINK   = 4'd7,
		PH_TAG    = 4'd8,
		PH_INVOKE = 4'd9,
		PH_DTFLAG = 4'd10,
		PH_DT     = 4'd11,
		PH_BODY   = 4'd12
	} phase_t;

	typedef enum logic [3:0] {
		KIND_LENGTH    = 4'd0,
		KIND_DEST_ADDR = 4'd1,
		KIND_SRC_ADDR  = 4'd2,
		KIND_CONTROL   = 4'd3,
		KIND_TAG       = 4'd4,
		KIND_INVOKE_ID = 4'd5,
		KIND_DATE_TIME = 4'd6,
		KIND_BODY      = 4'd7,
		KIND_ADDR_ERR  = 4'd8
	} kind_t;

	// Classified field as the front part hands it on. The count is the
	// address length or the date-time position, depending on the kind.
	typedef struct packed {
		kind_t       kind;
		logic [31:0] acc;
		logic [3:0]  cnt;
	} rec_t;

	typedef struct packed {
		logic push;
		rec_t rec;
	} queue_wr_t;

	typedef struct packed {
		logic valid;
		rec_t rec;
	} queue_rd_t;

endpackage

`default_nettype wire

// ===== rtl/hnhp_ifs.sv =====
// Handshake interfaces for the frame byte channel and the result channel.
`default_nettype none

interface hnhp_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface hnhp_result_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [31:0] value;
	logic [2:0]  address_bytes;
	logic [3:0]  byte_index;

	modport source (output valid, output kind, output value, output address_bytes,
		output byte_index, input ready);
	modport sink (input valid, input kind, input value, input address_bytes,
		input byte_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/hnhp_front.sv =====
// Front part: byte-wise header state machine that classifies each word.
`default_nettype none

module hnhp_front
	import hnhp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      accept,
	input  wire logic [7:0] data_byte,
	input  wire logic      frame_start,
	output queue_wr_t      wr
);

	phase_t      phase_q, phase_n;
	logic [3:0]  cnt_q, cnt_n;
	logic [31:0] acc_q, acc_n;
	logic [3:0]  cnt_inc;
	logic [31:0] acc_shift;
	logic [31:0] byte_ext;

	assign cnt_inc   = cnt_q + 4'd1;
	assign acc_shift = {acc_q[23:0], data_byte};
	assign byte_ext  = {24'd0, data_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= 4'd0;
			acc_q   <= 32'd0;
		end else if (accept) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			acc_q   <= acc_n;
		end
	end

	always_comb begin
		phase_n     = phase_q;
		cnt_n       = cnt_q;
		acc_n       = acc_q;
		wr.push     = 1'b0;
		wr.rec.kind = KIND_BODY;
		wr.rec.acc  = byte_ext;
		wr.rec.cnt  = 4'd0;

		if (frame_start) begin
			phase_n = PH_FMT1;
			cnt_n   = 4'd0;
			acc_n   = 32'd0;
		end else begin
			case (phase_q)
				PH_FMT1: begin
					acc_n   = byte_ext;
					phase_n = PH_FMT2;
				end
				PH_FMT2: begin
					wr.push     = accept;
					wr.rec.kind = KIND_LENGTH;
					wr.rec.acc  = acc_shift;
					phase_n     = PH_DEST;
					cnt_n       = 4'd0;
					acc_n       = 32'd0;
				end
				PH_DEST, PH_SRC: begin
					acc_n = acc_shift;
					cnt_n = cnt_inc;
					if (data_byte[0]) begin
						wr.push     = accept;
						wr.rec.kind = (phase_q == PH_DEST) ? KIND_DEST_ADDR : KIND_SRC_ADDR;
						wr.rec.acc  = acc_shift;
						wr.rec.cnt  = cnt_inc;
						phase_n     = (phase_q == PH_DEST) ? PH_SRC : PH_CTRL;
						cnt_n       = 4'd0;
						acc_n       = 32'd0;
					end else if (cnt_inc >= 4'(MAX_ADDRESS_BYTES)) begin
						// No terminating bit: report and wait for the next frame.
						wr.push     = accept;
						wr.rec.kind = KIND_ADDR_ERR;
						wr.rec.acc  = 32'd0;
						phase_n     = PH_IDLE;
						cnt_n       = 4'd0;
						acc_n       = 32'd0;
					end
				end
				PH_CTRL: begin
					wr.push     = accept;
					wr.rec.kind = KIND_CONTROL;
					phase_n     = PH_CHECK;
					cnt_n       = 4'd0;
					acc_n       = 32'd0;
				end
				PH_CHECK: begin
					cnt_n = cnt_inc;
					if (cnt_inc >= 4'(CHECK_BYTES)) begin
						phase_n = PH_LINK;
						cnt_n   = 4'd0;
						acc_n   = 32'd0;
					end
				end
				PH_LINK: begin
					cnt_n = cnt_inc;
					if (cnt_inc >= 4'(LINK_BYTES)) begin
						phase_n = PH_TAG;
						cnt_n   = 4'd0;
						acc_n   = 32'd0;
					end
				end
				PH_TAG: begin
					wr.push     = accept;
					wr.rec.kind = KIND_TAG;
					phase_n     = PH_INVOKE;
					cnt_n       = 4'd0;
					acc_n       = 32'd0;
				end
				PH_INVOKE: begin
					acc_n = acc_shift;
					cnt_n = cnt_inc;
					if (cnt_inc >= 4'(INVOKE_BYTES)) begin
						wr.push     = accept;
						wr.rec.kind = KIND_INVOKE_ID;
						wr.rec.acc  = acc_shift;
						phase_n     = PH_DTFLAG;
						cnt_n       = 4'd0;
						acc_n       = 32'd0;
					end
				end
				PH_DTFLAG: begin
					phase_n = (data_byte != 8'd0) ? PH_DT : PH_BODY;
					cnt_n   = 4'd0;
					acc_n   = 32'd0;
				end
				PH_DT: begin
					wr.push     = accept;
					wr.rec.kind = KIND_DATE_TIME;
					wr.rec.cnt  = cnt_q;
					cnt_n       = cnt_inc;
					if (cnt_inc >= 4'(DATE_TIME_BYTES)) begin
						phase_n = PH_BODY;
						cnt_n   = 4'd0;
						acc_n   = 32'd0;
					end
				end
				PH_BODY: begin
					wr.push     = accept;
					wr.rec.kind = KIND_BODY;
				end
				default: begin
					phase_n = PH_IDLE;
					cnt_n   = 4'd0;
					acc_n   = 32'd0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hnhp_queue.sv =====
// Short first-in first-out queue between the front and back parts.
`default_nettype none

module hnhp_queue
	import hnhp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire queue_wr_t wr,
	input  wire logic      pop,
	output queue_rd_t      rd,
	output logic           full
);

	rec_t                mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic                do_pop;

	assign full     = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign rd.valid = (count_q != '0);
	assign rd.rec   = mem[rd_ptr_q];
	assign do_pop   = pop && rd.valid;

	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem[wr_ptr_q] <= wr.rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr.push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !wr.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hnhp_back.sv =====
// Back part: formats queued fields into result words and holds the output register.
`default_nettype none

module hnhp_back
	import hnhp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire queue_rd_t rd,
	output logic           pop,
	hnhp_result_if.source  result
);

	logic        valid_q;
	logic [3:0]  kind_q;
	logic [31:0] value_q;
	logic [2:0]  abytes_q;
	logic [3:0]  index_q;
	logic [31:0] value_f;
	logic [2:0]  abytes_f;
	logic [3:0]  index_f;

	assign pop = rd.valid && (!valid_q || result.ready);

	always_comb begin
		value_f  = rd.rec.acc;
		abytes_f = 3'd0;
		index_f  = 4'd0;
		case (rd.rec.kind)
			KIND_LENGTH:                   value_f  = rd.rec.acc & LENGTH_MASK;
			KIND_DEST_ADDR, KIND_SRC_ADDR: abytes_f = rd.rec.cnt[2:0];
			KIND_DATE_TIME:                index_f  = rd.rec.cnt;
			KIND_ADDR_ERR:                 value_f  = 32'd0;
			default:                       value_f  = rd.rec.acc;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || result.ready) begin
			valid_q <= rd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= rd.rec.kind;
			value_q  <= value_f;
			abytes_q <= abytes_f;
			index_q  <= index_f;
		end
	end

	assign result.valid         = valid_q;
	assign result.kind          = kind_q;
	assign result.value         = value_q;
	assign result.address_bytes = abytes_q;
	assign result.byte_index    = index_q;

endmodule

`default_nettype wire

// ===== rtl/hdlc_notification_header_parser.sv =====
// Top level of the notification frame header parser.
`default_nettype none

// Channel  Role    Word contents
// -------  ------  --------------------------------------------------
// frame    sink    data_byte (8), frame_start (1)
// result   source  kind (4), value (32), address_bytes (3), byte_index (4)
//
// One frame word is taken every cycle while the four-entry queue has room;
// the byte-wide header state machine in the front part sets that rate.
// A result word passes through a queue entry and then the output register.
// Reset clears the parse phase, the queue pointers and the output valid.
// A stalled result channel fills the queue, and frame.ready then drops
// until the output register moves again.

module hdlc_notification_header_parser
	import hnhp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	hnhp_frame_if.sink    frame,
	hnhp_result_if.source result
);

	queue_wr_t wr;
	queue_rd_t rd;
	logic      pop;
	logic      full;
	logic      accept;

	// The front part stalls only when the queue is full.
	assign frame.ready = !full;
	assign accept      = frame.valid && frame.ready;

	hnhp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (frame.data_byte),
		.frame_start (frame.frame_start),
		.wr          (wr)
	);

	hnhp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.pop    (pop),
		.rd     (rd),
		.full   (full)
	);

	hnhp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (rd),
		.pop    (pop),
		.result (result)
	);

endmodule

`default_nettype wire
